@@ design/radix_digit_converter_unit_defines.svh @@
// Assertion macros used by the checker file of the radix digit converter.
`ifndef RADIX_DIGIT_CONVERTER_UNIT_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_UNIT_DEFINES_SVH

// Checked only while reset is low.
`define RDC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define RDC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rdc_pkg.sv @@
// Package with the sizes, types and digit glyph function of the radix digit converter.
package rdc_pkg;

   localparam int VALUE_BITS     = 31;
   localparam int DIGIT_SLOTS    = 32;
   localparam int RADIX_BITS     = 5;
   localparam int DIGIT_BITS     = 4;
   localparam int CHAR_BITS      = 7;
   localparam int REM_BITS       = 5;
   localparam int IDX_BITS       = $clog2(DIGIT_SLOTS);
   localparam int LEVEL_BITS     = $clog2(DIGIT_SLOTS + 1);
   localparam int CNT_BITS       = $clog2(VALUE_BITS + 1);
   localparam int REQ_TDATA_BITS = ((VALUE_BITS + RADIX_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((CHAR_BITS + 7) / 8) * 8;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_POP,
      ST_READ,
      ST_OUT
   } rdc_state_type;

   // Command to the digit stack.
   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic [DIGIT_BITS-1:0] data;
   } stack_cmd_type;

   // Result of the serial divider.
   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] quotient;
      logic [REM_BITS-1:0]   remainder;
   } div_out_type;

   // Maps a digit 0..15 to its ASCII character '0'-'9', 'A'-'F'.
   function automatic logic [CHAR_BITS-1:0] digit_glyph(input logic [DIGIT_BITS-1:0] digit);
      logic [CHAR_BITS-1:0] wide;
      wide = {{(CHAR_BITS - DIGIT_BITS){1'b0}}, digit};
      if (digit < DIGIT_BITS'(10)) begin
         return CHAR_BITS'(48) + wide;
      end else begin
         return CHAR_BITS'(55) + wide;
      end
   endfunction

endpackage

@@ design/radix_digit_converter_unit.sv @@
// For each digit the sequencer loads the divider, waits for its result and pushes the remainder.
// The serial divider works through all 31 value bits, one bit at a time, between start and finish.
// The most digits, 31, come from the largest value in base two; each is then popped, read and sent.
// One item at a time: req_tready is high only while the unit is idle.
// Reset is synchronous and active high; it empties the stack and returns to idle.
module radix_digit_converter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [30:0] number_in, [35:31] radix, [39:36] zero
   input  logic [rdc_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [6:0] digit_char, [7] zero
   output logic [rdc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import rdc_pkg::*;

   rdc_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic                  last_ff, last_in;
   logic [RADIX_BITS-1:0] radix_raw;
   logic                  div_start;
   div_out_type           div_out;
   stack_cmd_type         stack_cmd;
   logic [LEVEL_BITS-1:0] stack_level;
   logic [DIGIT_BITS-1:0] stack_digit;

   assign radix_raw = req_tdata[VALUE_BITS +: RADIX_BITS];

   rdc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (value_ff),
      .divisor  (radix_ff),
      .result   (div_out)
   );

   rdc_digit_stack u_stack (
      .clock   (clock),
      .reset   (reset),
      .cmd     (stack_cmd),
      .level   (stack_level),
      .rd_data (stack_digit)
   );

   // Sequencer: divide and push until the quotient is zero, then pop and send.
   always_comb begin
      state_in       = state_ff;
      value_in       = value_ff;
      radix_in       = radix_ff;
      last_in        = last_ff;
      div_start      = 1'b0;
      stack_cmd.push = 1'b0;
      stack_cmd.pop  = 1'b0;
      stack_cmd.data = div_out.remainder[DIGIT_BITS-1:0];
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               value_in = req_tdata[VALUE_BITS-1:0];
               if (radix_raw < RADIX_MIN) begin
                  radix_in = RADIX_MIN;
               end else if (radix_raw > RADIX_MAX) begin
                  radix_in = RADIX_MAX;
               end else begin
                  radix_in = radix_raw;
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_out.done) begin
               stack_cmd.push = 1'b1;
               value_in       = div_out.quotient;
               state_in       = (div_out.quotient == '0) ? ST_POP : ST_LOAD;
            end
         end
         ST_POP: begin
            stack_cmd.pop = 1'b1;
            last_in       = (stack_level == LEVEL_BITS'(1));
            state_in      = ST_READ;
         end
         ST_READ: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = last_ff ? ST_IDLE : ST_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_MIN;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         last_ff  <= last_in;
      end
   end

   // Remaining value to split.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign rsp_tdata = {{(RSP_TDATA_BITS - CHAR_BITS){1'b0}}, digit_glyph(stack_digit)};
   assign rsp_tlast = last_ff;

endmodule

@@ design/rdc_divider.sv @@
// Restoring bit-serial divider: one quotient bit per cycle.
module rdc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rdc_pkg::VALUE_BITS-1:0] dividend,
   input  logic [rdc_pkg::RADIX_BITS-1:0] divisor,
   output rdc_pkg::div_out_type           result
);
   import rdc_pkg::*;

   logic                  busy_ff, busy_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [REM_BITS:0]     trial;
   logic [REM_BITS:0]     diff;
   logic                  fits;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      trial   = {rem_ff, quo_ff[VALUE_BITS-1]};
      diff    = trial - {{(REM_BITS + 1 - RADIX_BITS){1'b0}}, divisor};
      fits    = trial >= {{(REM_BITS + 1 - RADIX_BITS){1'b0}}, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(VALUE_BITS);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_BITS'(1);
            quo_in = {quo_ff[VALUE_BITS-2:0], fits};
            rem_in = fits ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign result.done      = busy_ff && (cnt_ff == '0);
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

@@ design/rdc_digit_stack.sv @@
// Digit stack: a small memory with a level counter and registered read data.
module rdc_digit_stack (
   input  logic                           clock,
   input  logic                           reset,
   input  rdc_pkg::stack_cmd_type         cmd,
   output logic [rdc_pkg::LEVEL_BITS-1:0] level,
   output logic [rdc_pkg::DIGIT_BITS-1:0] rd_data
);
   import rdc_pkg::*;

   logic [DIGIT_BITS-1:0] mem [DIGIT_SLOTS];
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [LEVEL_BITS-1:0] top_level;
   logic [DIGIT_BITS-1:0] rd_data_ff;
   logic                  push_ok;

   // A push beyond the last slot is dropped; a pop reads the entry below the level.
   always_comb begin
      push_ok   = cmd.push && (level_ff < LEVEL_BITS'(DIGIT_SLOTS));
      top_level = level_ff - LEVEL_BITS'(1);
      level_in  = level_ff;
      if (push_ok) begin
         level_in = level_ff + LEVEL_BITS'(1);
      end else if (cmd.pop && (level_ff != '0)) begin
         level_in = top_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[level_ff[IDX_BITS-1:0]] <= cmd.data;
      end
      if (cmd.pop) begin
         rd_data_ff <= mem[top_level[IDX_BITS-1:0]];
      end
   end

   assign level   = level_ff;
   assign rd_data = rd_data_ff;

endmodule

@@ design/rdc_checker.sv @@
// Port-level checker for the radix digit converter, bound to the top level.
`include "radix_digit_converter_unit_defines.svh"

module rdc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rdc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tlast
);
   import rdc_pkg::*;

   logic req_accept;
   logic rsp_stall;
   logic legal_char;

   // Handshake shorthands and the set of legal digit characters.
   assign req_accept = req_tvalid && req_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign legal_char =
      ((rsp_tdata >= RSP_TDATA_BITS'(48)) && (rsp_tdata <= RSP_TDATA_BITS'(57))) ||
      ((rsp_tdata >= RSP_TDATA_BITS'(65)) && (rsp_tdata <= RSP_TDATA_BITS'(70)));

   // A stalled digit must keep its character and flag until it is taken.
   property p_hold_on_stall;
      rsp_stall |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast);
   endproperty

   // No new item is taken while a digit is on offer.
   `RDC_ASSERT(a_busy_on_output, clock, reset, rsp_tvalid |-> !req_tready, "ready while sending")

   // An accepted item keeps the unit busy in the next cycle.
   `RDC_ASSERT(a_busy_after_accept, clock, reset, req_accept |=> !req_tready, "ready after accept")

   // Every digit is an ASCII character 0-9 or A-F.
   `RDC_ASSERT(a_legal_char, clock, reset, rsp_tvalid |-> legal_char, "illegal digit character")

   // Nothing is offered in the cycle after reset.
   `RDC_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_tvalid, "output valid after reset")

   // A stalled digit holds its value and flag.
   `RDC_ASSERT(a_hold_on_stall, clock, reset, p_hold_on_stall, "stalled item changed")

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (.*);

@@ tb/sv/radix_digit_converter_unit_test.sv @@
// Self-checking testbench for the radix digit converter: random and directed values and bases.
module radix_digit_converter_unit_test;

   localparam int VBITS = rdc_pkg::VALUE_BITS;
   localparam int RBITS = rdc_pkg::RADIX_BITS;
   localparam int CBITS = rdc_pkg::CHAR_BITS;
   localparam int IDLE_LIMIT = 5000;
   localparam int TAIL_CYCLES = 1200;
   localparam logic [CBITS-1:0] ASCII_ZERO = CBITS'(8'h30);
   localparam logic [CBITS-1:0] ASCII_UPPER_A = CBITS'(8'h41);
   localparam logic [VBITS-1:0] VALUE_MAX = {VBITS{1'b1}};

   // One expected digit item: its character and whether it ends the number.
   typedef struct packed {
      logic [CBITS-1:0] glyph;
      logic             last;
   } digit_item_type;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [rdc_pkg::REQ_TDATA_BITS-1:0] req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [rdc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tlast;

   digit_item_type expected_digits[$];
   bit             idling_on;
   int             fail_count;
   int             values_sent;
   int             digits_checked;
   int             quiet_cycles;
   int             ready_hold;

   radix_digit_converter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Splits the value into digits of the clamped base and queues their characters,
   // most significant first.
   function automatic void predict_digits(input logic [VBITS-1:0] number,
                                          input logic [RBITS-1:0] radix_sel);
      int unsigned      base;
      logic [VBITS-1:0] rest;
      logic [3:0]       digits[$];
      digit_item_type   item;
      if (radix_sel < 2) begin
         base = 2;
      end else if (radix_sel > 16) begin
         base = 16;
      end else begin
         base = radix_sel;
      end
      rest = number;
      // A zero value still yields one digit.
      do begin
         digits.push_front(4'(rest % base));
         rest = VBITS'(rest / base);
      end while (rest != 0);
      foreach (digits[i]) begin
         if (digits[i] < 10) begin
            item.glyph = ASCII_ZERO + CBITS'(digits[i]);
         end else begin
            item.glyph = ASCII_UPPER_A + CBITS'(digits[i] - 10);
         end
         item.last = (i == digits.size() - 1);
         expected_digits.push_back(item);
      end
   endfunction

   // Sends one value and base; called and returning at a falling edge.
   task automatic send_item(input logic [VBITS-1:0] number, input logic [RBITS-1:0] radix_sel);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = '0;
      req_tdata[VBITS-1:0] = number;
      req_tdata[VBITS+RBITS-1:VBITS] = radix_sel;
      do @(posedge clock); while (!req_tready);
      predict_digits(number, radix_sel);
      values_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Holds the sender back until every queued digit has come out.
   task automatic wait_for_drain();
      while (expected_digits.size() != 0) @(negedge clock);
   endtask

   // Random value whose magnitude is spread over all bit lengths.
   function automatic logic [VBITS-1:0] random_value();
      logic [VBITS-1:0] mask;
      mask = (VBITS'(1) << $urandom_range(1, VBITS)) - VBITS'(1);
      if ($urandom_range(0, 15) == 0) begin
         return '0;
      end
      return VBITS'($urandom) & mask;
   endfunction

   // Zero in a spread of bases, clamped ones included.
   task automatic test_zero_value();
      send_item('0, RBITS'(0));
      send_item('0, RBITS'(2));
      send_item('0, RBITS'(10));
      send_item('0, RBITS'(31));
      wait_for_drain();
   endtask

   // Bases below two and above sixteen, and legal bases from three to fifteen.
   task automatic test_radix_clamp();
      send_item(VBITS'(5), RBITS'(0));
      send_item(VBITS'(6), RBITS'(1));
      send_item(VBITS'(255), RBITS'(17));
      send_item(VBITS'(1234), RBITS'(31));
      send_item(VBITS'(100), RBITS'(3));
      send_item(VBITS'(64), RBITS'(8));
      send_item(VBITS'(81), RBITS'(9));
      send_item(VBITS'(14), RBITS'(15));
      wait_for_drain();
   endtask

   // Largest value, single largest digits, value equal to the base, and alternating bit patterns.
   task automatic test_value_extremes();
      send_item(VALUE_MAX, RBITS'(2));
      send_item(VALUE_MAX, RBITS'(16));
      send_item(VALUE_MAX, RBITS'(10));
      send_item(VALUE_MAX, RBITS'(7));
      send_item(VBITS'(1), RBITS'(2));
      send_item(VBITS'(15), RBITS'(16));
      send_item(VBITS'(9), RBITS'(10));
      send_item(VBITS'(16), RBITS'(16));
      send_item(VBITS'(31'h2AAA_AAAA), RBITS'(2));
      send_item(VBITS'(31'h5555_5555), RBITS'(2));
      wait_for_drain();
   endtask

   // Random values with mostly legal bases and some out of range.
   task automatic test_random_mix(input int count);
      logic [RBITS-1:0] radix_sel;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            radix_sel = RBITS'($urandom_range(0, 31));
         end else begin
            radix_sel = RBITS'($urandom_range(2, 16));
         end
         send_item(random_value(), radix_sel);
         // Now and then let the converter run dry before going on.
         if ($urandom_range(0, 24) == 0) begin
            wait_for_drain();
         end
      end
      wait_for_drain();
   endtask

   // Result side: ready drops in random bursts while idling is on.
   initial begin
      rsp_tready = 1'b0;
      ready_hold = 0;
      forever begin
         @(negedge clock);
         if (ready_hold > 0) begin
            rsp_tready = 1'b0;
            ready_hold--;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_tready = 1'b0;
            ready_hold = $urandom_range(1, 4) - 1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Compares each accepted digit item with the oldest prediction.
   always @(posedge clock) begin
      digit_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_digits.size() == 0) begin
            $error("unexpected digit item: digit_char %0d last_digit %0b",
                   rsp_tdata[CBITS-1:0], rsp_tlast);
            fail_count++;
         end else begin
            want = expected_digits.pop_front();
            digits_checked++;
            if (rsp_tdata[CBITS-1:0] !== want.glyph) begin
               $error("digit_char mismatch: expected %0d actual %0d",
                      want.glyph, rsp_tdata[CBITS-1:0]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_digit mismatch: expected %0b actual %0b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Ends the run if neither side moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved in %0d cycles", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      idling_on = 1'b1;
      fail_count = 0;
      values_sent = 0;
      digits_checked = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_zero_value();
      test_radix_clamp();
      test_value_extremes();
      test_random_mix(250);
      // Closing stretch without any idling on either side.
      idling_on = 1'b0;
      test_random_mix(50);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_digits.size() != 0) begin
         $error("%0d digit items never arrived", expected_digits.size());
         fail_count++;
      end
      $display("Converted %0d values across bases 0..31, including clamped bases and zero.",
               values_sent);
      $display("Checked %0d digit items under random input gaps and output stalls.",
               digits_checked);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
